/* sv/sobel_pkg.sv */
// ---------------------------------------------------------------------------
// sobel_pkg
// Shared constants and types of the 3x3 Sobel edge filter: image limits,
// field widths and configuration register indexes.
// ---------------------------------------------------------------------------
package sobel_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W  = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 11;
  localparam int FILL_W = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W  = 12;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);

  typedef enum logic [1:0] {
    REG_DIRECTION    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  // {line a (row r-1), line b (row r-2)}
  typedef struct packed {
    pix_t a;
    pix_t b;
  } line_pair_t;

  typedef struct packed {
    logic             emit;
    logic             bord;
    logic             last;
    logic [ROW_W-1:0] crow;
    logic [COL_W-1:0] ccol;
    logic [COL_W-1:0] addr;
    pix_t             px;
  } stage_t;

endpackage

/* sv/sobel_3x3_convolution.sv */
// ---------------------------------------------------------------------------
// sobel_3x3_convolution
// Streaming 3x3 Sobel X / Sobel Y edge filter with two line stores.
//
// Pixels enter on the in_ channel in raster order, one transfer per pixel;
// in_frame_start marks pixel (0,0). The result for centre (r-1,c-1) leaves
// on the out_ channel when pixel (r,c) has been taken; first row and first
// column inputs give no result. Border centres come out as 0 with out_border
// set, and out_frame_end flags the result of the last pixel of a frame.
// Kernel choice and image size sit in APB registers at byte addresses
// 0 (direction), 4 (image_width) and 8 (image_height); sizes take the low
// 11 bits of the write data and are clamped to 3..1024 when written.
// Throughput is one pixel per cycle while the receiver keeps up. A pixel
// transfer loads the registered line store read stage; when the output
// register is free, the window shift and kernel sum load into it.
// When the receiver stalls, the result holds in the output register and one
// more pixel is taken into the read stage before in_ready falls.
// Reset sets the configuration to defaults and clears counters and valid
// flags; line store contents are tracked by a fill count, so unwritten
// columns read as zero without a clearing pass.
// ---------------------------------------------------------------------------
module sobel_3x3_convolution
  import sobel_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel_in,
  input  logic              in_frame_start,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_pixel_out,
  output logic [ROW_W-1:0]  out_centre_row,
  output logic [COL_W-1:0]  out_centre_col,
  output logic              out_border,
  output logic              out_frame_end,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic              direction_r;
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [SIZE_W-1:0] size_wr;
  logic              cfg_wr;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  line_pair_t        mem [MAX_WIDTH];
  line_pair_t        rd_r;
  line_pair_t        fwd_data_r;
  line_pair_t        wr_data;
  line_pair_t        up_eff;
  logic              fwd_r;
  logic              hit_r;

  stage_t            s1_r, s0;
  logic              s1_valid_r;
  logic              out_free;
  logic              s1_go;
  logic              in_acc;

  logic [ROW_W-1:0]  r0;
  logic [COL_W-1:0]  c0;
  logic              row_end;
  logic              frame_last;

  pix_t              win_r [3][3];
  pix_t              nw    [3][3];
  logic signed [SUM_W-1:0] sum;
  pix_t              clamped;

  logic              out_valid_r;
  pix_t              out_pix_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              out_bord_r;
  logic              out_last_r;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  always_comb begin
    size_wr = pwdata[SIZE_W-1:0];
    if (size_wr < MIN_SIZE) begin
      size_wr = MIN_SIZE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      width_r     <= MAX_W_SIZE;
      height_r    <= MAX_H_SIZE;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_DIRECTION: begin
          direction_r <= pwdata[0];
        end
        REG_IMAGE_WIDTH: begin
          width_r <= (size_wr > MAX_W_SIZE) ? MAX_W_SIZE : size_wr;
        end
        REG_IMAGE_HEIGHT: begin
          height_r <= (size_wr > MAX_H_SIZE) ? MAX_H_SIZE : size_wr;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_DIRECTION:    prdata = DATA_W'(direction_r);
      REG_IMAGE_WIDTH:  prdata = DATA_W'(width_r);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(height_r);
      default:          prdata = '0;
    endcase
  end

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_acc   = in_valid && in_ready;

  // position of the incoming pixel
  always_comb begin
    r0         = in_frame_start ? '0 : row_r;
    c0         = in_frame_start ? '0 : col_r;
    row_end    = ({1'b0, c0} + SIZE_W'(1)) >= width_r;
    frame_last = row_end && (({1'b0, r0} + SIZE_W'(1)) >= height_r);
    if (row_end) begin
      col_nxt = '0;
      row_nxt = frame_last ? '0 : r0 + ROW_W'(1);
    end else begin
      col_nxt = c0 + COL_W'(1);
      row_nxt = r0;
    end
    s0.px   = in_pixel_in;
    s0.addr = c0;
    s0.emit = (r0 != '0) && (c0 != '0);
    s0.crow = r0 - ROW_W'(1);
    s0.ccol = c0 - COL_W'(1);
    s0.bord = (s0.crow == '0) || (s0.ccol == '0);
    s0.last = frame_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // line store read stage
  assign up_eff  = fwd_r ? fwd_data_r : (hit_r ? rd_r : '0);
  assign wr_data = '{a: s1_r.px, b: up_eff.a};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r       <= mem[c0];
      hit_r      <= {1'b0, c0} < fill_r;
      fwd_r      <= s1_go && (s1_r.addr == c0);
      fwd_data_r <= wr_data;
      s1_r       <= s0;
    end
    if (s1_go) begin
      mem[s1_r.addr] <= wr_data;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if ({1'b0, s1_r.addr} >= fill_r) begin
      fill_nxt = {1'b0, s1_r.addr} + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fill_r     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // window shift and kernel sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nw[i][0] = win_r[i][1];
      nw[i][1] = win_r[i][2];
    end
    nw[0][2] = up_eff.b;
    nw[1][2] = up_eff.a;
    nw[2][2] = s1_r.px;
    if (!direction_r) begin
      sum = $signed({4'b0, nw[0][2]}) + ($signed({4'b0, nw[1][2]}) <<< 1)
          + $signed({4'b0, nw[2][2]}) - $signed({4'b0, nw[0][0]})
          - ($signed({4'b0, nw[1][0]}) <<< 1) - $signed({4'b0, nw[2][0]});
    end else begin
      sum = $signed({4'b0, nw[2][0]}) + ($signed({4'b0, nw[2][1]}) <<< 1)
          + $signed({4'b0, nw[2][2]}) - $signed({4'b0, nw[0][0]})
          - ($signed({4'b0, nw[0][1]}) <<< 1) - $signed({4'b0, nw[0][2]});
    end
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > $signed(SUM_W'(255))) begin
      clamped = '1;
    end else begin
      clamped = sum[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_r      <= nw;
      out_pix_r  <= s1_r.bord ? '0 : clamped;
      out_row_r  <= s1_r.crow;
      out_col_r  <= s1_r.ccol;
      out_bord_r <= s1_r.bord;
      out_last_r <= s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= s1_r.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_centre_row = out_row_r;
  assign out_centre_col = out_col_r;
  assign out_border     = out_bord_r;
  assign out_frame_end  = out_last_r;

endmodule
